/* src/lsd_pkg.sv */
// ----------------------------------------------------------------------------
// lsd_pkg
// Shared codes and types for the LIFO stack with dup and swap.
// ----------------------------------------------------------------------------
`default_nettype none

package lsd_pkg;

	// request action codes
	typedef logic [2:0] action_t;
	localparam action_t ACT_PUSH  = 3'd0;
	localparam action_t ACT_POP   = 3'd1;
	localparam action_t ACT_PEEK  = 3'd2;
	localparam action_t ACT_DUP   = 3'd3;
	localparam action_t ACT_SWAP  = 3'd4;
	localparam action_t ACT_CLEAR = 3'd5;

	// result status codes
	typedef logic [1:0] status_t;
	localparam status_t STAT_OK    = 2'd0;
	localparam status_t STAT_EMPTY = 2'd1;
	localparam status_t STAT_FULL  = 2'd2;

	localparam int WORD_W   = 64;

	typedef logic [WORD_W-1:0] word_t;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	// update control from the action decoder
	typedef struct packed {
		logic    wr_en;
		logic    top_we;
		status_t status;
	} upd_ctl_t;

endpackage

`default_nettype wire

/* src/lsd_ram.sv */
// ----------------------------------------------------------------------------
// lsd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lsd_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, hold while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* src/lsd_update.sv */
// ----------------------------------------------------------------------------
// lsd_update
// Action decoder: from the count, the top register and the word read below
// the top, works out the result, the new count, the new top and the write.
// ----------------------------------------------------------------------------
`default_nettype none

module lsd_update #(
	parameter int DEPTH = 128
) (
	input  wire logic [2:0]                     action,
	input  wire logic [63:0]                    push_word,
	input  wire logic [$clog2(DEPTH+1)-1:0]     count,
	input  wire logic [63:0]                    top,
	input  wire logic [63:0]                    below,
	output      logic [63:0]                    result,
	output      logic [$clog2(DEPTH+1)-1:0]     new_count,
	output      logic [63:0]                    new_top,
	output      logic [$clog2(DEPTH)-1:0]       wr_addr,
	output      logic [63:0]                    wr_data,
	output      lsd_pkg::upd_ctl_t              ctl
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);

	logic          empty;
	logic          full;
	logic          two_plus;
	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] cnt_m2;
	logic [63:0]   top_or_zero;

	assign empty       = (count == '0);
	assign full        = (count == CW'(DEPTH));
	assign two_plus    = (count > CW'(1));
	assign cnt_m1      = count - CW'(1);
	assign cnt_m2      = count - CW'(2);
	assign top_or_zero = empty ? 64'd0 : top;

	// decode the action
	always_comb begin
		result     = top_or_zero;
		new_count  = count;
		new_top    = top;
		wr_addr    = cnt_m1[AW-1:0];
		wr_data    = top;
		ctl.wr_en  = 1'b0;
		ctl.top_we = 1'b0;
		ctl.status = lsd_pkg::STAT_OK;
		unique case (action)
			lsd_pkg::ACT_PUSH: begin
				if (full) begin
					ctl.status = lsd_pkg::STAT_FULL;
				end else begin
					// spill the old top into memory, the new word becomes top
					ctl.wr_en  = !empty;
					ctl.top_we = 1'b1;
					new_top    = push_word;
					new_count  = count + CW'(1);
					result     = push_word;
				end
			end
			lsd_pkg::ACT_POP: begin
				if (empty) begin
					ctl.status = lsd_pkg::STAT_EMPTY;
				end else begin
					ctl.top_we = 1'b1;
					new_top    = below;
					new_count  = cnt_m1;
					result     = top;
				end
			end
			lsd_pkg::ACT_PEEK: begin
				if (empty) begin
					ctl.status = lsd_pkg::STAT_EMPTY;
				end
			end
			lsd_pkg::ACT_DUP: begin
				if (empty) begin
					ctl.status = lsd_pkg::STAT_EMPTY;
				end else if (full) begin
					ctl.status = lsd_pkg::STAT_FULL;
				end else begin
					ctl.wr_en = 1'b1;
					new_count = count + CW'(1);
				end
			end
			lsd_pkg::ACT_SWAP: begin
				if (!two_plus) begin
					ctl.status = lsd_pkg::STAT_EMPTY;
				end else begin
					// old top goes below, the entry below becomes top
					ctl.wr_en  = 1'b1;
					ctl.top_we = 1'b1;
					wr_addr    = cnt_m2[AW-1:0];
					new_top    = below;
					result     = below;
				end
			end
			lsd_pkg::ACT_CLEAR: begin
				new_count = '0;
				result    = 64'd0;
			end
			default: begin
				result = top_or_zero;
			end
		endcase
	end

endmodule

`default_nettype wire

/* src/lifo_stack_dup_swap.sv */
// ----------------------------------------------------------------------------
// lifo_stack_dup_swap
// Bounded LIFO stack of 64-bit words with push, pop, peek, dup, swap and
// clear. The top entry lives in a register, the rest in a synchronous RAM.
// ----------------------------------------------------------------------------
//  channel | dir | signals                 | content
//  --------+-----+-------------------------+---------------------------------
//  s_      | in  | s_tvalid/tready/tdata   | request: action, push_word
//  m_      | out | m_tvalid/tready/tdata   | result: out_word, depth, status
//
//  In the accept cycle the RAM reads the entry below the top; in the S_EXEC
//  state the top register, count and RAM are updated.
//  The registered read port of the RAM sets this split into two states.
//  A new request is taken while a result waits in the output register.
//  Reset empties the stack at once; the RAM is not cleared.
//  A held result stalls the update cycle until the output slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module lifo_stack_dup_swap #(
	parameter int DEPTH = 128
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [71:0] s_tdata,   // [2:0] action, [66:3] push_word
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [79:0] m_tdata    // [63:0] out_word, [71:64] depth, [73:72] status
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);

	lsd_pkg::state_t    state_q;
	logic [CW-1:0]      count_q;
	logic [63:0]        top_q;
	logic [2:0]         action_s1;
	logic [63:0]        word_s1;
	logic               m_valid_q;
	logic [63:0]        m_word_q;
	logic [7:0]         m_depth_q;
	logic [1:0]         m_status_q;

	logic               accept;
	logic               slot_free;
	logic               commit;
	logic [CW-1:0]      cnt_m2;
	logic [63:0]        below;
	logic [63:0]        result;
	logic [CW-1:0]      new_count;
	logic [63:0]        new_top;
	logic [AW-1:0]      wr_addr;
	logic [63:0]        wr_data;
	lsd_pkg::upd_ctl_t  ctl;
	logic [CW+7:0]      depth_ext;

	assign s_tready  = (state_q == lsd_pkg::S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign slot_free = !m_valid_q || m_tready;
	assign commit    = (state_q == lsd_pkg::S_EXEC) && slot_free;
	assign cnt_m2    = count_q - CW'(2);
	assign depth_ext = {8'd0, new_count};

	// entries below the top
	lsd_ram #(
		.WIDTH(64),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (commit && ctl.wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (accept),
		.raddr (cnt_m2[AW-1:0]),
		.rdata (below)
	);

	lsd_update #(
		.DEPTH(DEPTH)
	) u_update (
		.action    (action_s1),
		.push_word (word_s1),
		.count     (count_q),
		.top       (top_q),
		.below     (below),
		.result    (result),
		.new_count (new_count),
		.new_top   (new_top),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.ctl       (ctl)
	);

	// sequence accept and update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lsd_pkg::S_IDLE;
		end else begin
			unique case (state_q)
				lsd_pkg::S_IDLE: begin
					if (accept) state_q <= lsd_pkg::S_EXEC;
				end
				lsd_pkg::S_EXEC: begin
					if (slot_free) state_q <= lsd_pkg::S_IDLE;
				end
				default: state_q <= lsd_pkg::S_IDLE;
			endcase
		end
	end

	// capture the request
	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= s_tdata[2:0];
			word_s1   <= s_tdata[66:3];
		end
	end

	// update count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (commit) begin
			count_q <= new_count;
		end
	end

	// update top register
	always_ff @(posedge clk) begin
		if (commit && ctl.top_we) begin
			top_q <= new_top;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (commit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (commit) begin
			m_word_q   <= result;
			m_depth_q  <= depth_ext[7:0];
			m_status_q <= ctl.status;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'd0, m_status_q, m_depth_q, m_word_q};

`ifndef ASSERT_OFF
	a_commit_valid : assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> m_valid_q)
		else $error("result not presented after update");

	a_count_bound : assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("stack count above depth");

	a_accept_exec : assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == lsd_pkg::S_EXEC) && !s_tready)
		else $error("accepted request not executed");

	a_state_onehot : assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("controller state not one-hot");
`endif

endmodule

`default_nettype wire
